[hw/rtl/variable_width_integer_alu_unit_macros.svh]
// Assertion macros for the variable-width integer ALU.
`ifndef VARIABLE_WIDTH_INTEGER_ALU_UNIT_MACROS_SVH
`define VARIABLE_WIDTH_INTEGER_ALU_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VWALU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define VWALU_CHECK_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

[hw/rtl/vwalu_pkg.sv]
// Shared types and constants for the variable-width integer ALU.
`default_nettype none
package vwalu_pkg;

  localparam int unsigned MaxWidthDefault = 64;
  localparam int unsigned FullBits = 64;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MOD = 4'd4,
    CMD_EQ  = 4'd5,
    CMD_NE  = 4'd6,
    CMD_LT  = 4'd7,
    CMD_LE  = 4'd8,
    CMD_GT  = 4'd9,
    CMD_GE  = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [3:0]          command;
    logic [FullBits-1:0] lhs_value;
    logic [FullBits-1:0] rhs_value;
    logic [6:0]          operand_width;
    logic                signed_op;
  } req_t;

  typedef struct packed {
    logic [FullBits-1:0] result_value;
    logic                divide_by_zero;
  } rsp_t;

  // Control that travels with each transaction down the pipe.
  typedef struct packed {
    logic valid;
    cmd_e cmd;
    logic sgn;
    logic na;
    logic nb;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

[hw/rtl/vwalu_prep.sv]
// Operand preparation stage: width clamp, mask, sign extension, magnitudes.
`default_nettype none
module vwalu_prep #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::MaxWidthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 req_valid,
  input  wire vwalu_pkg::req_t      req,
  output vwalu_pkg::ctl_t           ctl,
  output logic [MAX_WIDTH-1:0]      a,
  output logic [MAX_WIDTH-1:0]      b,
  output logic [MAX_WIDTH-1:0]      msk,
  output logic [MAX_WIDTH-1:0]      ua,
  output logic [MAX_WIDTH-1:0]      ub
);
  localparam int unsigned IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [6:0] MW7 = 7'(MAX_WIDTH);

  logic [6:0]           w;
  logic [6:0]           top;
  logic [MAX_WIDTH-1:0] m;
  logic [MAX_WIDTH-1:0] am;
  logic [MAX_WIDTH-1:0] bm;
  logic [MAX_WIDTH-1:0] a_next;
  logic [MAX_WIDTH-1:0] b_next;
  logic                 na;
  logic                 nb;

  // Clamp width, cut operands and extend the sign
  always_comb begin
    if (req.operand_width == 7'd0) begin
      w = 7'd1;
    end else if (req.operand_width > MW7) begin
      w = MW7;
    end else begin
      w = req.operand_width;
    end
    top = w - 7'd1;
    m = {MAX_WIDTH{1'b1}} >> (MW7 - w);
    am = req.lhs_value[MAX_WIDTH-1:0] & m;
    bm = req.rhs_value[MAX_WIDTH-1:0] & m;
    a_next = (req.signed_op && am[top[IW-1:0]]) ? (am | ~m) : am;
    b_next = (req.signed_op && bm[top[IW-1:0]]) ? (bm | ~m) : bm;
    na = req.signed_op && a_next[MAX_WIDTH-1];
    nb = req.signed_op && b_next[MAX_WIDTH-1];
  end

  // Register the prepared transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= req_valid;
    end
    if (en) begin
      ctl.cmd <= vwalu_pkg::cmd_e'(req.command);
      ctl.sgn <= req.signed_op;
      ctl.na  <= na;
      ctl.nb  <= nb;
      ctl.dz  <= (b_next == '0);
      a   <= a_next;
      b   <= b_next;
      msk <= m;
      ua  <= na ? -a_next : a_next;
      ub  <= nb ? -b_next : b_next;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/vwalu_div_step.sv]
// One restoring division step, one quotient bit per pipeline stage.
`default_nettype none
module vwalu_div_step #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::MaxWidthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire vwalu_pkg::ctl_t      prev_ctl,
  input  wire logic [MAX_WIDTH-1:0] prev_a,
  input  wire logic [MAX_WIDTH-1:0] prev_b,
  input  wire logic [MAX_WIDTH-1:0] prev_msk,
  input  wire logic [MAX_WIDTH-1:0] prev_ub,
  input  wire logic [MAX_WIDTH-1:0] prev_rem,
  input  wire logic [MAX_WIDTH-1:0] prev_dq,
  output vwalu_pkg::ctl_t           ctl,
  output logic [MAX_WIDTH-1:0]      a,
  output logic [MAX_WIDTH-1:0]      b,
  output logic [MAX_WIDTH-1:0]      msk,
  output logic [MAX_WIDTH-1:0]      ub,
  output logic [MAX_WIDTH-1:0]      rem,
  output logic [MAX_WIDTH-1:0]      dq
);
  logic [MAX_WIDTH:0]   shifted;
  logic [MAX_WIDTH:0]   diff;
  logic                 ge;
  logic [MAX_WIDTH-1:0] rem_next;
  logic [MAX_WIDTH-1:0] dq_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted  = {prev_rem, prev_dq[MAX_WIDTH-1]};
    diff     = shifted - {1'b0, prev_ub};
    ge       = (shifted >= {1'b0, prev_ub});
    rem_next = ge ? diff[MAX_WIDTH-1:0] : shifted[MAX_WIDTH-1:0];
    dq_next  = {prev_dq[MAX_WIDTH-2:0], ge};
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= prev_ctl.valid;
    end
    if (en) begin
      ctl.cmd <= prev_ctl.cmd;
      ctl.sgn <= prev_ctl.sgn;
      ctl.na  <= prev_ctl.na;
      ctl.nb  <= prev_ctl.nb;
      ctl.dz  <= prev_ctl.dz;
      a   <= prev_a;
      b   <= prev_b;
      msk <= prev_msk;
      ub  <= prev_ub;
      rem <= rem_next;
      dq  <= dq_next;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/vwalu_tail.sv]
// Tail stages: multiplier partial products, add, compare, quotient sign, select.
`default_nettype none
module vwalu_tail #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::MaxWidthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire vwalu_pkg::ctl_t      prev_ctl,
  input  wire logic [MAX_WIDTH-1:0] prev_a,
  input  wire logic [MAX_WIDTH-1:0] prev_b,
  input  wire logic [MAX_WIDTH-1:0] prev_msk,
  input  wire logic [MAX_WIDTH-1:0] prev_rem,
  input  wire logic [MAX_WIDTH-1:0] prev_q,
  output logic                      rsp_valid,
  output vwalu_pkg::rsp_t           rsp
);
  localparam int unsigned H  = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HI = MAX_WIDTH - H;

  logic [H-1:0]         al;
  logic [H-1:0]         bl;
  logic [HI-1:0]        ah;
  logic [HI-1:0]        bh;
  logic [H+HI-1:0]      pa;
  logic [H+HI-1:0]      pb;
  logic [MAX_WIDTH-1:0] ka;
  logic [MAX_WIDTH-1:0] kb;
  logic [MAX_WIDTH-1:0] res_next;
  logic                 dz_next;

  logic                 s_valid;
  vwalu_pkg::cmd_e      s_cmd;
  logic [MAX_WIDTH-1:0] s_msk;
  logic [MAX_WIDTH-1:0] s_res;
  logic                 s_dz;
  logic [2*H-1:0]       s_ll;
  logic [HI-1:0]        s_cross;
  logic [MAX_WIDTH-1:0] prod;

  // Split operands, form the non-multiply results
  always_comb begin
    al = prev_a[H-1:0];
    bl = prev_b[H-1:0];
    ah = prev_a[MAX_WIDTH-1:H];
    bh = prev_b[MAX_WIDTH-1:H];
    pa = al * bh;
    pb = ah * bl;
    ka = prev_a ^ {prev_ctl.sgn, {(MAX_WIDTH-1){1'b0}}};
    kb = prev_b ^ {prev_ctl.sgn, {(MAX_WIDTH-1){1'b0}}};
    dz_next = 1'b0;
    case (prev_ctl.cmd)
      vwalu_pkg::CMD_ADD: res_next = (prev_a + prev_b) & prev_msk;
      vwalu_pkg::CMD_SUB: res_next = (prev_a - prev_b) & prev_msk;
      vwalu_pkg::CMD_DIV: begin
        dz_next = prev_ctl.dz;
        if (prev_ctl.dz) begin
          res_next = '0;
        end else begin
          res_next = ((prev_ctl.na ^ prev_ctl.nb) ? -prev_q : prev_q) & prev_msk;
        end
      end
      vwalu_pkg::CMD_MOD: begin
        dz_next = prev_ctl.dz;
        if (prev_ctl.dz) begin
          res_next = '0;
        end else begin
          res_next = (prev_ctl.na ? -prev_rem : prev_rem) & prev_msk;
        end
      end
      vwalu_pkg::CMD_EQ: res_next = MAX_WIDTH'(prev_a == prev_b);
      vwalu_pkg::CMD_NE: res_next = MAX_WIDTH'(prev_a != prev_b);
      vwalu_pkg::CMD_LT: res_next = MAX_WIDTH'(ka < kb);
      vwalu_pkg::CMD_LE: res_next = MAX_WIDTH'(ka <= kb);
      vwalu_pkg::CMD_GT: res_next = MAX_WIDTH'(ka > kb);
      vwalu_pkg::CMD_GE: res_next = MAX_WIDTH'(ka >= kb);
      default:           res_next = '0;
    endcase
  end

  // Hold partial products and the early result
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= prev_ctl.valid;
    end
    if (en) begin
      s_cmd   <= prev_ctl.cmd;
      s_msk   <= prev_msk;
      s_res   <= res_next;
      s_dz    <= dz_next;
      s_ll    <= al * bl;
      s_cross <= pa[HI-1:0] + pb[HI-1:0];
    end
  end

  // Sum the truncated product
  assign prod = s_ll[MAX_WIDTH-1:0] + {s_cross, {H{1'b0}}};

  // Select and register the response
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= s_valid;
    end
    if (en) begin
      rsp.result_value   <= vwalu_pkg::FullBits'((s_cmd == vwalu_pkg::CMD_MUL) ?
                                                 (prod & s_msk) : s_res);
      rsp.divide_by_zero <= s_dz;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/variable_width_integer_alu_unit.sv]
// Variable-width integer ALU: add, sub, mul, div, mod and compares at 1..MAX_WIDTH bits.
// A new transaction is accepted every cycle unless the response is stalled.
// A transaction passes through one operand preparation register, one restoring
// division stage per quotient bit, one stage for multiplier partial products,
// add and compare, and the response register. The whole pipe advances together
// and freezes while a response waits on rsp_ready. Division or modulo by zero
// returns 0 with divide_by_zero set; the signed minimum divided by minus one wraps.
`default_nettype none
`include "variable_width_integer_alu_unit_macros.svh"
module variable_width_integer_alu_unit #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::MaxWidthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire vwalu_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output vwalu_pkg::rsp_t      rsp
);
  logic en;

  vwalu_pkg::ctl_t      ctl [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] a   [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] b   [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] msk [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] ub  [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] rem [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] dq  [MAX_WIDTH+1];

  // Advance the pipe whenever the response slot is free or taken
  assign en = !rsp_valid || rsp_ready;
  assign req_ready = en && !rst;

  vwalu_prep #(.MAX_WIDTH(MAX_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .ctl       (ctl[0]),
    .a         (a[0]),
    .b         (b[0]),
    .msk       (msk[0]),
    .ua        (dq[0]),
    .ub        (ub[0])
  );
  assign rem[0] = '0;

  // Chain the division steps
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_div
    vwalu_div_step #(.MAX_WIDTH(MAX_WIDTH)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .prev_ctl (ctl[i]),
      .prev_a   (a[i]),
      .prev_b   (b[i]),
      .prev_msk (msk[i]),
      .prev_ub  (ub[i]),
      .prev_rem (rem[i]),
      .prev_dq  (dq[i]),
      .ctl      (ctl[i+1]),
      .a        (a[i+1]),
      .b        (b[i+1]),
      .msk      (msk[i+1]),
      .ub       (ub[i+1]),
      .rem      (rem[i+1]),
      .dq       (dq[i+1])
    );
  end

  vwalu_tail #(.MAX_WIDTH(MAX_WIDTH)) u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .prev_ctl  (ctl[MAX_WIDTH]),
    .prev_a    (a[MAX_WIDTH]),
    .prev_b    (b[MAX_WIDTH]),
    .prev_msk  (msk[MAX_WIDTH]),
    .prev_rem  (rem[MAX_WIDTH]),
    .prev_q    (dq[MAX_WIDTH]),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // A divide-by-zero response always comes with a zero result
  `VWALU_CHECK(a_dz_zero, !(rsp_valid && rsp.divide_by_zero) || rsp.result_value == '0, "dz nonzero")
  // A stalled response freezes the first stage
  `VWALU_CHECK_NEXT(a_stall_hold, rsp_valid && !rsp_ready, $stable(ctl[0]) && $stable(a[0]), "stall moved")
endmodule
`default_nettype wire
